// ===== rtl/ppc_pkg.sv =====
// Package for the polygon plane clipper: sizes, vertex type and register indexes.
// Used by ppc_mul, ppc_div and polygon_plane_clipper_core; depends on nothing.
package ppc_pkg;

	localparam int MAX_VERTICES = 8;
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);

	localparam int COORD_W = 32;
	localparam int MUL_W   = COORD_W + 1;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int DIST_W  = PROD_W + 1;
	localparam int DEN_W   = DIST_W + 1;
	localparam int T_W     = 17;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd5;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} vec3_t;

	// Select one axis of a vector: 0 is x, 1 is y, anything else is z.
	function automatic logic signed [COORD_W-1:0] vec_get(input vec3_t v, input logic [1:0] k);
		logic signed [COORD_W-1:0] r;
		unique case (k)
			2'd0: r = v.x;
			2'd1: r = v.y;
			default: r = v.z;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/ppc_mul.sv =====
// Shared signed multiplier of the polygon plane clipper, product registered.
// Depends on ppc_pkg.
module ppc_mul (
	input  logic                              clk,
	input  logic signed [ppc_pkg::MUL_W-1:0]  a,
	input  logic signed [ppc_pkg::MUL_W-1:0]  b,
	output logic signed [ppc_pkg::PROD_W-1:0] p_q
);

	// One product per cycle, available the cycle after the operands.
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ===== rtl/ppc_div.sv =====
// Restoring divider giving the unsigned Q1.16 edge ratio num / den, one bit a cycle.
// Depends on ppc_pkg.
module ppc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ppc_pkg::DEN_W-1:0]     num,
	input  logic [ppc_pkg::DEN_W-1:0]     den,
	output logic                          done_q,
	output logic [ppc_pkg::T_W-1:0]       quo
);

	logic                        busy_q;
	logic                        zero_q;
	logic [4:0]                  step_q;
	logic [ppc_pkg::DEN_W:0]     r_q;
	logic [ppc_pkg::DEN_W-1:0]   d_q;
	logic [ppc_pkg::T_W-1:0]     q_q;
	logic [ppc_pkg::DEN_W:0]     rs;
	logic                        ge;

	// The first step compares without a shift to produce the integer bit.
	always_comb begin
		rs = (step_q == 5'd0) ? r_q : {r_q[ppc_pkg::DEN_W-1:0], 1'b0};
		ge = rs >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'(ppc_pkg::T_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			r_q    <= {1'b0, num};
			d_q    <= den;
			zero_q <= (den == '0);
			q_q    <= '0;
		end else if (busy_q) begin
			r_q <= ge ? rs - {1'b0, d_q} : rs;
			q_q <= {q_q[ppc_pkg::T_W-2:0], ge};
		end
	end

	// A zero denominator yields a zero ratio.
	assign quo = zero_q ? '0 : q_q;

endmodule

// ===== rtl/polygon_plane_clipper_core.sv =====
// Polygon plane clipper top level: vertex store, clip sequencer, result buffer.
// Vertices are stored one per accepted request while idle. A clip walks the stored
// vertices in order: distance to the plane, a decision, and for a crossing a divide and
// an interpolation; kept vertices and crossings go to the result buffer, which is then
// presented one result at a time. One shared multiplier and one bit-serial divider serve
// the clip; no new request is taken until the last result is delivered. Reset (arst_n low) clears the plane
// registers, vertex count, overflow flags and sequencer; stores are not cleared.
// Depends on ppc_pkg, ppc_mul and ppc_div.
module polygon_plane_clipper_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ppc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ppc_pkg::COORD_W-1:0]         cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [ppc_pkg::COORD_W-1:0]  vx,
	input  logic signed [ppc_pkg::COORD_W-1:0]  vy,
	input  logic signed [ppc_pkg::COORD_W-1:0]  vz,
	input  logic                                final_vertex,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [ppc_pkg::COORD_W-1:0]  ox,
	output logic signed [ppc_pkg::COORD_W-1:0]  oy,
	output logic signed [ppc_pkg::COORD_W-1:0]  oz,
	output logic                                vertex_valid,
	output logic                                overflow,
	output logic                                run_end
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DIST   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_LERP   = 3'd4;
	localparam logic [2:0] S_PUTCUR = 3'd5;
	localparam logic [2:0] S_NEXT   = 3'd6;
	localparam logic [2:0] S_EMIT   = 3'd7;

	localparam logic [ppc_pkg::CNT_W-1:0] CNT_MAX = ppc_pkg::CNT_W'(ppc_pkg::MAX_VERTICES);

	// Plane registers.
	ppc_pkg::vec3_t normal_q, origin_q;

	// Vertex store and result buffer (no reset: only written entries are read).
	ppc_pkg::vec3_t store_q [ppc_pkg::MAX_VERTICES];
	ppc_pkg::vec3_t res_mem [ppc_pkg::MAX_VERTICES];

	logic [2:0]                      state_q;
	logic                            out_wait_q;
	logic [ppc_pkg::CNT_W-1:0]       count_q, n_q, rc_q;
	logic [ppc_pkg::IDX_W-1:0]       idx_q, oidx_q;
	logic [1:0]                      ksub_q;
	logic                            first_q;
	logic                            inovf_q, oovf_q;
	logic signed [ppc_pkg::DIST_W-1:0] acc_q, pd_q, cd_q;
	logic                            pin_q, cin_q;
	ppc_pkg::vec3_t                  pv_q;
	logic [ppc_pkg::T_W-1:0]         t_q;
	logic signed [ppc_pkg::COORD_W-1:0] lx_q, ly_q;

	ppc_pkg::vec3_t                  cur;
	logic signed [ppc_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic signed [ppc_pkg::PROD_W-1:0] p_q;
	logic signed [ppc_pkg::DIST_W-1:0] cd_sum;
	logic                            cd_in;
	logic signed [ppc_pkg::COORD_W-1:0] lerp_v;
	logic [1:0]                      lerp_axis;
	logic [ppc_pkg::DEN_W-1:0]       abs_p, abs_c;
	logic                            div_start, div_done;
	logic [ppc_pkg::T_W-1:0]         div_quo;
	logic                            put_req, res_we;
	ppc_pkg::vec3_t                  res_wd;
	logic                            in_acc, full;
	logic [ppc_pkg::CNT_W-1:0]       n_new;
	logic                            last_edge, last_out;

	assign cur      = store_q[idx_q];
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign full     = (count_q == CNT_MAX);
	assign n_new    = full ? count_q : count_q + 1'b1;
	assign last_edge = ({1'b0, idx_q} + 1'b1) == n_q;
	assign last_out  = ({1'b0, oidx_q} + 1'b1) == rc_q;
	assign out_valid = out_wait_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_q <= '0;
			origin_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ppc_pkg::REG_NORMAL_X: normal_q.x <= cfg_wdata;
				ppc_pkg::REG_NORMAL_Y: normal_q.y <= cfg_wdata;
				ppc_pkg::REG_NORMAL_Z: normal_q.z <= cfg_wdata;
				ppc_pkg::REG_ORIGIN_X: origin_q.x <= cfg_wdata;
				ppc_pkg::REG_ORIGIN_Y: origin_q.y <= cfg_wdata;
				ppc_pkg::REG_ORIGIN_Z: origin_q.z <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Shared multiplier operands: distance terms, then interpolation terms.
	always_comb begin
		if (state_q == S_LERP) begin
			mul_a = ppc_pkg::MUL_W'(ppc_pkg::vec_get(cur, ksub_q))
				- ppc_pkg::MUL_W'(ppc_pkg::vec_get(pv_q, ksub_q));
			mul_b = ppc_pkg::MUL_W'({1'b0, t_q});
		end else begin
			mul_a = ppc_pkg::MUL_W'(ppc_pkg::vec_get(cur, ksub_q))
				- ppc_pkg::MUL_W'(ppc_pkg::vec_get(origin_q, ksub_q));
			mul_b = ppc_pkg::MUL_W'(ppc_pkg::vec_get(normal_q, ksub_q));
		end
	end

	ppc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	// Distance accumulation and the inside test (at most zero is inside).
	assign cd_sum = acc_q + ppc_pkg::DIST_W'(p_q);
	assign cd_in  = cd_sum[ppc_pkg::DIST_W-1] || (cd_sum == '0);

	// Interpolated coordinate: prev plus the floored product over 65536.
	assign lerp_axis = ksub_q - 2'd1;
	assign lerp_v    = ppc_pkg::vec_get(pv_q, lerp_axis) + p_q[47:16];

	// Divider operands: |d_prev| over |d_prev| + |d_cur|.
	assign abs_p     = ppc_pkg::DEN_W'(pd_q[ppc_pkg::DIST_W-1] ? -pd_q : pd_q);
	assign abs_c     = ppc_pkg::DEN_W'(cd_q[ppc_pkg::DIST_W-1] ? -cd_q : cd_q);
	assign div_start = (state_q == S_DECIDE) && (pin_q != cin_q);

	ppc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (abs_p),
		.den    (abs_p + abs_c),
		.done_q (div_done),
		.quo    (div_quo)
	);

	// Result buffer write: a crossing or the current vertex.
	always_comb begin
		put_req = 1'b0;
		res_wd  = cur;
		if (state_q == S_LERP && ksub_q == 2'd3) begin
			put_req = 1'b1;
			res_wd  = '{x: lx_q, y: ly_q, z: lerp_v};
		end else if (state_q == S_PUTCUR) begin
			put_req = 1'b1;
		end
	end
	assign res_we = put_req && (rc_q != CNT_MAX);

	// Store and buffer writes, result register loads.
	always_ff @(posedge clk) begin
		if (in_acc && !full) begin
			store_q[count_q[ppc_pkg::IDX_W-1:0]] <= '{x: vx, y: vy, z: vz};
		end
		if (res_we) begin
			res_mem[rc_q[ppc_pkg::IDX_W-1:0]] <= res_wd;
		end
		if (state_q == S_EMIT && !out_wait_q) begin
			if (rc_q == '0) begin
				ox <= '0;
				oy <= '0;
				oz <= '0;
				vertex_valid <= 1'b0;
				run_end      <= 1'b1;
			end else begin
				ox <= res_mem[oidx_q].x;
				oy <= res_mem[oidx_q].y;
				oz <= res_mem[oidx_q].z;
				vertex_valid <= 1'b1;
				run_end      <= last_out;
			end
			overflow <= inovf_q || oovf_q;
		end
	end

	// Datapath registers of the clip walk.
	always_ff @(posedge clk) begin
		if (state_q == S_DIST) begin
			if (ksub_q == 2'd1) begin
				acc_q <= ppc_pkg::DIST_W'(p_q);
			end else if (ksub_q == 2'd2) begin
				acc_q <= cd_sum;
			end else if (ksub_q == 2'd3) begin
				if (first_q) begin
					pv_q  <= cur;
					pd_q  <= cd_sum;
					pin_q <= cd_in;
				end else begin
					cd_q  <= cd_sum;
					cin_q <= cd_in;
				end
			end
		end
		if (state_q == S_DIV && div_done) begin
			t_q <= div_quo;
		end
		if (state_q == S_LERP) begin
			if (ksub_q == 2'd1) begin
				lx_q <= lerp_v;
			end else if (ksub_q == 2'd2) begin
				ly_q <= lerp_v;
			end
		end
		if (state_q == S_NEXT) begin
			pv_q  <= cur;
			pd_q  <= cd_q;
			pin_q <= cin_q;
		end
	end

	// Clip sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			out_wait_q <= 1'b0;
			count_q    <= '0;
			n_q        <= '0;
			rc_q       <= '0;
			idx_q      <= '0;
			oidx_q     <= '0;
			ksub_q     <= '0;
			first_q    <= 1'b0;
			inovf_q    <= 1'b0;
			oovf_q     <= 1'b0;
		end else begin
			if (put_req && !res_we) begin
				oovf_q <= 1'b1;
			end
			if (res_we) begin
				rc_q <= rc_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (full) begin
							inovf_q <= 1'b1;
						end
						if (final_vertex) begin
							count_q <= '0;
							n_q     <= n_new;
							idx_q   <= ppc_pkg::IDX_W'(n_new - 1'b1);
							rc_q    <= '0;
							oovf_q  <= 1'b0;
							first_q <= 1'b1;
							ksub_q  <= '0;
							state_q <= S_DIST;
						end else begin
							count_q <= n_new;
						end
					end
				end
				S_DIST: begin
					ksub_q <= ksub_q + 2'd1;
					if (ksub_q == 2'd3) begin
						if (first_q) begin
							first_q <= 1'b0;
							idx_q   <= '0;
						end else begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					if (pin_q != cin_q) begin
						state_q <= S_DIV;
					end else if (cin_q) begin
						state_q <= S_PUTCUR;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						ksub_q  <= '0;
						state_q <= S_LERP;
					end
				end
				S_LERP: begin
					ksub_q <= ksub_q + 2'd1;
					if (ksub_q == 2'd3) begin
						state_q <= cin_q ? S_PUTCUR : S_NEXT;
					end
				end
				S_PUTCUR: begin
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					ksub_q <= '0;
					if (last_edge) begin
						oidx_q  <= '0;
						state_q <= S_EMIT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_DIST;
					end
				end
				S_EMIT: begin
					if (!out_wait_q) begin
						out_wait_q <= 1'b1;
					end else if (out_ready) begin
						out_wait_q <= 1'b0;
						if (run_end) begin
							inovf_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							oidx_q <= oidx_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A result is only presented while the sequencer is emitting.
	a_out_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == S_EMIT && !in_ready))
		else $error("result presented outside the emit phase");

	// The result count never exceeds the buffer depth.
	a_rc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rc_q <= CNT_MAX)
		else $error("result count beyond buffer depth");

	// The divider only finishes while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

	// Delivering the last result returns the block to accepting requests.
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && run_end) |=> in_ready)
		else $error("block did not return to idle after the last result");

endmodule
